FILE: design/vcms_pkg.sv
// Package: shared constants and types for the vertex cover move scorer.
`timescale 1ns / 1ps
package vcms_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int SCORE_W      = 44;
    localparam int TOTAL_W      = 43;
    localparam int WEIGHT_W     = 31;
    localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = 31'd2147483646;

    typedef enum logic [2:0] {
        FUNC_LOAD   = 3'd0,
        FUNC_ADD    = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_READ_U = 3'd3,
        FUNC_READ_V = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SAME    = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;
endpackage

FILE: design/vcms_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface vcms_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [9:0]  vertex;
    logic [9:0]  other_vertex;
    logic [30:0] weight;
    logic [11:0] position;
    modport source (output valid, func, vertex, other_vertex, weight, position, input ready);
    modport sink   (input valid, func, vertex, other_vertex, weight, position, output ready);
endinterface

interface vcms_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [42:0]        uncovered_weight;
    logic [12:0]        uncovered_edges;
    logic [10:0]        cover_size;
    logic [11:0]        edge_found;
    logic [9:0]         edge_end_a;
    logic [9:0]         edge_end_b;
    logic signed [43:0] vertex_score;
    logic               vertex_in_cover;
    logic               vertex_changed;
    modport source (output valid, status, uncovered_weight, uncovered_edges, cover_size,
                    edge_found, edge_end_a, edge_end_b, vertex_score, vertex_in_cover,
                    vertex_changed, input ready);
    modport sink   (input valid, status, uncovered_weight, uncovered_edges, cover_size,
                    edge_found, edge_end_a, edge_end_b, vertex_score, vertex_in_cover,
                    vertex_changed, output ready);
endinterface

FILE: design/vertex_cover_move_scorer.sv
// Top level: vertex cover move scorer with sequencer and memories.
`timescale 1ns / 1ps
// One word at a time; ready is low while an item is in work. Add and remove
// walk over every stored edge, unless the vertex is already in the requested
// state. An edge that touches the vertex has its neighbor read and written
// back through a single shared 44-bit adder; when that edge also leaves the
// uncovered list, the last list entry is moved into its slot. After reset a
// clearing pass initializes every entry of the vertex memory; no word is
// taken then. Results wait in an output register, and the next word is taken
// the cycle after the result is accepted.
module vertex_cover_move_scorer #(
    parameter int MAX_VERTICES = vcms_pkg::MAX_VERTICES,
    parameter int MAX_EDGES    = vcms_pkg::MAX_EDGES
) (
    input logic clk,
    input logic rst_n,
    vcms_req_if.sink   req,
    vcms_rsp_if.source rsp
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int SW = vcms_pkg::SCORE_W;
    localparam int TW = vcms_pkg::TOTAL_W;
    localparam int WW = vcms_pkg::WEIGHT_W;

    // vertex memory: {in_cover, changed, score}
    logic [SW+1:0]  vmem [MAX_VERTICES];
    logic [VW-1:0]  ea_mem [MAX_EDGES];
    logic [VW-1:0]  eb_mem [MAX_EDGES];
    logic [WW-1:0]  w_mem  [MAX_EDGES];
    logic [EW-1:0]  ul_mem [MAX_EDGES];
    logic [EW-1:0]  lp_mem [MAX_EDGES];

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE,
        S_LD_RD_A, S_LD_RD_B, S_LD_WR_A, S_LD_WR_B,
        S_FL_RD, S_FL_WR, S_E_RD, S_E_CHK, S_N_RD, S_N_WR,
        S_TK_RD, S_TK_WR, S_RU_RD, S_RU_E, S_RU_OUT,
        S_RV_RD, S_RESP
    } state_t;

    state_t          state_reg;
    logic [VW:0]     clr_reg;
    logic [2:0]      func_reg;
    logic [9:0]      v_reg, u_reg;
    logic [WW-1:0]   w_reg;
    logic [11:0]     pos_reg;
    logic [EW:0]     edges_reg, fill_reg, e_reg;
    logic [TW-1:0]   total_reg;
    logic [VW:0]     cover_reg;
    logic            join_reg;
    logic [VW-1:0]   n_reg;
    logic [EW-1:0]   found_reg;
    logic [SW+1:0]   va_reg, vb_reg;

    // memory read data
    logic [SW+1:0]   vrd_reg;
    logic [VW-1:0]   ea_rd_reg, eb_rd_reg;
    logic [WW-1:0]   w_rd_reg;
    logic [EW-1:0]   ul_rd_reg, lp_rd_reg;

    // memory request controls
    logic            vwe;
    logic [VW-1:0]   vaddr, vwaddr;
    logic [SW+1:0]   vwdata;
    logic [EW-1:0]   eaddr;
    logic            ewe;
    logic [EW-1:0]   ul_raddr, lp_raddr;

    // shared adder
    logic [SW-1:0]   add_a, add_b, add_y;
    logic            add_sub;
    assign add_y = add_sub ? add_a - add_b : add_a + add_b;

    // response payload registers
    logic            rvalid_reg;
    logic [1:0]      rstat_reg;
    logic [11:0]     rfound_reg;
    logic [9:0]      rea_reg, reb_reg;
    logic [SW+1:0]   rvert_reg;
    logic            rshow_reg;

    logic [WW-1:0]   w_clip;
    assign w_clip = (req.weight > vcms_pkg::MAX_WEIGHT) ? vcms_pkg::MAX_WEIGHT : req.weight;

    assign req.ready = (state_reg == S_IDLE) && !rvalid_reg;

    // memory address selection
    always_comb
    begin
        vaddr = v_reg[VW-1:0];
        case (state_reg)
            S_LD_RD_B: vaddr = u_reg[VW-1:0];
            S_N_RD:    vaddr = n_reg;
            default:   vaddr = v_reg[VW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            vmem[vwaddr] <= vwdata;
        vrd_reg <= vmem[vaddr];
        if (ewe)
        begin
            ea_mem[eaddr] <= v_reg[VW-1:0];
            eb_mem[eaddr] <= u_reg[VW-1:0];
            w_mem[eaddr]  <= w_reg;
        end
        ea_rd_reg <= ea_mem[eaddr];
        eb_rd_reg <= eb_mem[eaddr];
        w_rd_reg  <= w_mem[eaddr];
        ul_rd_reg <= ul_mem[ul_raddr];
        lp_rd_reg <= lp_mem[lp_raddr];
    end

    // uncovered list ports
    logic            ulwe, lpwe;
    logic [EW-1:0]   ulwa, ulwd, lpwa, lpwd;
    always_ff @(posedge clk)
    begin
        if (ulwe)
            ul_mem[ulwa] <= ulwd;
        if (lpwe)
            lp_mem[lpwa] <= lpwd;
    end

    logic [EW-1:0] fill_m1;
    assign fill_m1 = EW'(fill_reg - 1'b1);

    always_comb
    begin
        vwe = 1'b0; vwaddr = v_reg[VW-1:0]; vwdata = '0;
        ewe = 1'b0; eaddr = e_reg[EW-1:0];
        ulwe = 1'b0; ulwa = fill_reg[EW-1:0]; ulwd = e_reg[EW-1:0];
        lpwe = 1'b0; lpwa = e_reg[EW-1:0]; lpwd = fill_reg[EW-1:0];
        ul_raddr = pos_reg[EW-1:0]; lp_raddr = e_reg[EW-1:0];
        add_a = '0; add_b = '0; add_sub = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                vwe = 1'b1; vwaddr = clr_reg[VW-1:0]; vwdata = {1'b0, 1'b1, {SW{1'b0}}};
            end
            S_DECODE:
                eaddr = edges_reg[EW-1:0];
            S_LD_WR_A:
            begin
                // vrd_reg holds the second endpoint in this state
                ewe = 1'b1; eaddr = edges_reg[EW-1:0];
                add_a = va_reg[SW-1:0]; add_b = SW'(w_reg);
                add_sub = va_reg[SW+1];
                vwe = !vrd_reg[SW+1];
                vwaddr = v_reg[VW-1:0];
                vwdata = {va_reg[SW+1:SW], add_y};
                if (!va_reg[SW+1] && !vrd_reg[SW+1])
                begin
                    ulwe = 1'b1; ulwa = fill_reg[EW-1:0]; ulwd = edges_reg[EW-1:0];
                    lpwe = 1'b1; lpwa = edges_reg[EW-1:0]; lpwd = fill_reg[EW-1:0];
                end
            end
            S_LD_WR_B:
            begin
                add_a = vb_reg[SW-1:0]; add_b = SW'(w_reg);
                add_sub = vb_reg[SW+1];
                vwe = !vb_reg[SW+1] && !va_reg[SW+1] || (vb_reg[SW+1] && !va_reg[SW+1]);
                vwaddr = u_reg[VW-1:0];
                vwdata = {vb_reg[SW+1:SW], add_y};
            end
            S_FL_WR:
            begin
                // a redundant add or remove leaves the vertex untouched
                add_a = '0; add_b = vrd_reg[SW-1:0]; add_sub = 1'b1;
                vwe = (vrd_reg[SW+1] != join_reg); vwaddr = v_reg[VW-1:0];
                vwdata = {join_reg, 1'b0, add_y};
            end
            S_N_WR:
            begin
                add_a = vrd_reg[SW-1:0]; add_b = SW'(w_rd_reg);
                add_sub = vrd_reg[SW+1] ? !join_reg : join_reg;
                vwe = 1'b1; vwaddr = n_reg;
                vwdata = {vrd_reg[SW+1], 1'b1, add_y};
                if (!vrd_reg[SW+1] && !join_reg)
                begin
                    ulwe = 1'b1; ulwa = fill_reg[EW-1:0]; ulwd = e_reg[EW-1:0];
                    lpwe = 1'b1; lpwa = e_reg[EW-1:0]; lpwd = fill_reg[EW-1:0];
                end
                ul_raddr = fill_m1; lp_raddr = e_reg[EW-1:0];
            end
            S_TK_RD:
            begin
                // fill_reg already points at the last entry
                ul_raddr = fill_reg[EW-1:0]; lp_raddr = e_reg[EW-1:0];
            end
            S_TK_WR:
            begin
                ulwe = 1'b1; ulwa = lp_rd_reg; ulwd = ul_rd_reg;
                lpwe = 1'b1; lpwa = ul_rd_reg; lpwd = lp_rd_reg;
            end
            S_RU_RD:
                ul_raddr = pos_reg[EW-1:0];
            S_RU_E:
                eaddr = ul_rd_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            edges_reg  <= '0;
            fill_reg   <= '0;
            total_reg  <= '0;
            cover_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                rvalid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (VW+1)'(MAX_VERTICES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (req.valid && req.ready)
                    begin
                        func_reg <= req.func;
                        v_reg    <= req.vertex;
                        u_reg    <= req.other_vertex;
                        w_reg    <= w_clip;
                        pos_reg  <= req.position;
                        state_reg <= S_DECODE;
                    end
                S_DECODE:
                begin
                    rstat_reg <= vcms_pkg::ST_OK;
                    rfound_reg <= '0; rea_reg <= '0; reb_reg <= '0;
                    rshow_reg <= 1'b0;
                    state_reg <= S_RESP;
                    case (func_reg)
                        vcms_pkg::FUNC_LOAD:
                        begin
                            rshow_reg <= 32'(v_reg) < MAX_VERTICES;
                            if (32'(edges_reg) >= MAX_EDGES || 32'(v_reg) >= MAX_VERTICES
                                || 32'(u_reg) >= MAX_VERTICES || v_reg == u_reg)
                            begin
                                rstat_reg <= vcms_pkg::ST_RANGE;
                                state_reg <= (32'(v_reg) < MAX_VERTICES) ? S_RV_RD : S_RESP;
                            end
                            else
                                state_reg <= S_LD_RD_A;
                        end
                        vcms_pkg::FUNC_ADD, vcms_pkg::FUNC_REMOVE:
                        begin
                            join_reg <= (func_reg == vcms_pkg::FUNC_ADD);
                            if (32'(v_reg) >= MAX_VERTICES)
                                rstat_reg <= vcms_pkg::ST_RANGE;
                            else
                            begin
                                rshow_reg <= 1'b1;
                                state_reg <= S_FL_RD;
                            end
                        end
                        vcms_pkg::FUNC_READ_U:
                            if (13'(pos_reg) >= 13'(fill_reg) || 32'(pos_reg) >= MAX_EDGES)
                                rstat_reg <= vcms_pkg::ST_RANGE;
                            else
                                state_reg <= S_RU_RD;
                        vcms_pkg::FUNC_READ_V:
                            if (32'(v_reg) >= MAX_VERTICES)
                                rstat_reg <= vcms_pkg::ST_RANGE;
                            else
                            begin
                                rshow_reg <= 1'b1;
                                state_reg <= S_RV_RD;
                            end
                        default:
                            rstat_reg <= vcms_pkg::ST_RANGE;
                    endcase
                end
                S_LD_RD_A: state_reg <= S_LD_RD_B;
                S_LD_RD_B:
                begin
                    va_reg <= vrd_reg;
                    state_reg <= S_LD_WR_A;
                end
                S_LD_WR_A:
                begin
                    vb_reg <= vrd_reg;
                    state_reg <= S_LD_WR_B;
                end
                S_LD_WR_B:
                begin
                    edges_reg <= edges_reg + 1'b1;
                    if (!va_reg[SW+1] && !vb_reg[SW+1])
                    begin
                        fill_reg  <= fill_reg + 1'b1;
                        total_reg <= total_reg + TW'(w_reg);
                    end
                    state_reg <= S_RV_RD;
                end
                S_FL_RD: state_reg <= S_FL_WR;
                S_FL_WR:
                begin
                    if (vrd_reg[SW+1] == join_reg)
                    begin
                        rstat_reg <= vcms_pkg::ST_SAME;
                        state_reg <= S_RV_RD;
                    end
                    else
                    begin
                        cover_reg <= join_reg ? cover_reg + 1'b1 : cover_reg - 1'b1;
                        e_reg <= '0;
                        state_reg <= S_E_RD;
                    end
                end
                S_E_RD:
                    state_reg <= (e_reg >= edges_reg) ? S_RV_RD : S_E_CHK;
                S_E_CHK:
                begin
                    if (ea_rd_reg == v_reg[VW-1:0])
                    begin
                        n_reg <= eb_rd_reg; state_reg <= S_N_RD;
                    end
                    else if (eb_rd_reg == v_reg[VW-1:0])
                    begin
                        n_reg <= ea_rd_reg; state_reg <= S_N_RD;
                    end
                    else
                    begin
                        e_reg <= e_reg + 1'b1; state_reg <= S_E_RD;
                    end
                end
                S_N_RD: state_reg <= S_N_WR;
                S_N_WR:
                begin
                    if (!vrd_reg[SW+1])
                    begin
                        if (join_reg)
                        begin
                            fill_reg  <= fill_reg - 1'b1;
                            total_reg <= total_reg - TW'(w_rd_reg);
                            state_reg <= S_TK_RD;
                        end
                        else
                        begin
                            fill_reg  <= fill_reg + 1'b1;
                            total_reg <= total_reg + TW'(w_rd_reg);
                            e_reg <= e_reg + 1'b1; state_reg <= S_E_RD;
                        end
                    end
                    else
                    begin
                        e_reg <= e_reg + 1'b1; state_reg <= S_E_RD;
                    end
                end
                S_TK_RD: state_reg <= S_TK_WR;
                S_TK_WR:
                begin
                    e_reg <= e_reg + 1'b1; state_reg <= S_E_RD;
                end
                S_RU_RD: state_reg <= S_RU_E;
                S_RU_E:
                begin
                    found_reg <= ul_rd_reg;
                    state_reg <= S_RU_OUT;
                end
                S_RU_OUT:
                begin
                    rfound_reg <= 12'(found_reg);
                    rea_reg <= 10'(ea_rd_reg);
                    reb_reg <= 10'(eb_rd_reg);
                    state_reg <= S_RESP;
                end
                S_RV_RD: state_reg <= S_RESP;
                S_RESP:
                begin
                    rvert_reg  <= vrd_reg;
                    rvalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid            = rvalid_reg;
    assign rsp.status           = rstat_reg;
    assign rsp.uncovered_weight = total_reg;
    assign rsp.uncovered_edges  = 13'(fill_reg);
    assign rsp.cover_size       = 11'(cover_reg);
    assign rsp.edge_found       = rfound_reg;
    assign rsp.edge_end_a       = rea_reg;
    assign rsp.edge_end_b       = reb_reg;
    assign rsp.vertex_score     = rshow_reg ? signed'(rvert_reg[SW-1:0]) : '0;
    assign rsp.vertex_in_cover  = rshow_reg & rvert_reg[SW+1];
    assign rsp.vertex_changed   = rshow_reg & rvert_reg[SW];

    // the list never holds more edges than are loaded
    a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= edges_reg)
        else $error("uncovered list longer than edge store");
    // no word is taken while a result waits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n) rvalid_reg |-> !req.ready)
        else $error("request taken with pending result");
    // cover count moves by at most one per cycle
    a_cov: assert property (@(posedge clk) disable iff (!rst_n)
        (cover_reg == $past(cover_reg)) || (cover_reg == $past(cover_reg) + 1'b1)
        || (cover_reg == $past(cover_reg) - 1'b1))
        else $error("cover count jumped");
endmodule

FILE: sim/vertex_cover_move_scorer_test.sv
// Testbench: directed and random checks of the vertex cover move scorer.
`timescale 1ns / 1ps
module vertex_cover_move_scorer_test;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        vcms_pkg::status_t status;
        logic [42:0]  unc_weight;
        logic [12:0]  unc_edges;
        logic [10:0]  cover_cnt;
        logic [11:0]  found;
        logic [9:0]   end_a;
        logic [9:0]   end_b;
        logic [43:0]  score;
        logic         in_cov;
        logic         changed;
    } scorer_result_t;

    typedef struct {
        logic [2:0]  func;
        logic [9:0]  vtx;
        logic [9:0]  other;
        logic [30:0] wgt;
        logic [11:0] pos;
        bit          typed;    // status below is known by inspection
        vcms_pkg::status_t status;
    } scorer_word_t;

    logic clk;
    logic rst_n;
    vcms_req_if req_ch ();
    vcms_rsp_if rsp_ch ();

    vertex_cover_move_scorer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ---------------- mirror of the block's graph and cover ----------------
    bit          cov_mirror [vcms_pkg::MAX_VERTICES];
    logic [43:0] score_mirror [vcms_pkg::MAX_VERTICES];
    bit          mark_mirror [vcms_pkg::MAX_VERTICES];
    logic [9:0]  end_a_mirror [vcms_pkg::MAX_EDGES];
    logic [9:0]  end_b_mirror [vcms_pkg::MAX_EDGES];
    logic [30:0] weight_mirror [vcms_pkg::MAX_EDGES];
    int          loaded_edges;
    int          unc_list [vcms_pkg::MAX_EDGES];
    int          unc_slot [vcms_pkg::MAX_EDGES];
    int          unc_fill;
    logic [42:0] unc_total;
    int          cover_count;

    scorer_result_t pending_results [$];
    int  mismatches;
    bit  quiet;          // no idling on either side
    bit  hold_request;   // receiver holds ready low for a long stretch
    int  cycle_count;

    // Uncovered list: append at the end, remove by moving the last entry in.
    function automatic void unc_append(int e);
        unc_slot[e] = unc_fill;
        unc_list[unc_fill] = e;
        unc_fill++;
        unc_total = unc_total + 43'(weight_mirror[e]);
    endfunction

    function automatic void unc_remove(int e);
        int last;
        unc_fill--;
        last = unc_list[unc_fill];
        unc_list[unc_slot[e]] = last;
        unc_slot[last] = unc_slot[e];
        unc_total = unc_total - 43'(weight_mirror[e]);
    endfunction

    // Flip cover membership of v, then walk incident edges in index order.
    function automatic void flip_cover(int v, bit joining);
        int n;
        logic [43:0] w;
        cov_mirror[v] = joining;
        score_mirror[v] = -score_mirror[v];
        mark_mirror[v] = 1'b0;
        cover_count += joining ? 1 : -1;
        for (int e = 0; e < loaded_edges; e++)
        begin
            if (end_a_mirror[e] == v)
                n = end_b_mirror[e];
            else if (end_b_mirror[e] == v)
                n = end_a_mirror[e];
            else
                continue;
            w = 44'(weight_mirror[e]);
            if (!cov_mirror[n])
            begin
                if (joining)
                begin
                    score_mirror[n] -= w;
                    unc_remove(e);
                end
                else
                begin
                    score_mirror[n] += w;
                    unc_append(e);
                end
            end
            else
                score_mirror[n] = joining ? score_mirror[n] + w : score_mirror[n] - w;
            mark_mirror[n] = 1'b1;
        end
    endfunction

    function automatic scorer_result_t score_move(scorer_word_t wd);
        scorer_result_t r;
        bit show;
        int v;
        int u;
        int e;
        logic [30:0] w;
        r = '{status: vcms_pkg::ST_OK, default: '0};
        show = 1'b0;
        v = wd.vtx;
        u = wd.other;
        case (wd.func)
            vcms_pkg::FUNC_LOAD:
            begin
                show = 1'b1;
                if (loaded_edges >= vcms_pkg::MAX_EDGES || v == u)
                    r.status = vcms_pkg::ST_RANGE;
                else
                begin
                    w = (wd.wgt > vcms_pkg::MAX_WEIGHT) ? vcms_pkg::MAX_WEIGHT : wd.wgt;
                    e = loaded_edges++;
                    end_a_mirror[e] = v;
                    end_b_mirror[e] = u;
                    weight_mirror[e] = w;
                    if (!cov_mirror[v] && !cov_mirror[u])
                    begin
                        score_mirror[v] += 44'(w);
                        score_mirror[u] += 44'(w);
                        unc_append(e);
                    end
                    else if (cov_mirror[v] && !cov_mirror[u])
                        score_mirror[v] -= 44'(w);
                    else if (!cov_mirror[v] && cov_mirror[u])
                        score_mirror[u] -= 44'(w);
                end
            end
            vcms_pkg::FUNC_ADD, vcms_pkg::FUNC_REMOVE:
            begin
                show = 1'b1;
                if (cov_mirror[v] == (wd.func == vcms_pkg::FUNC_ADD))
                    r.status = vcms_pkg::ST_SAME;
                else
                    flip_cover(v, wd.func == vcms_pkg::FUNC_ADD);
            end
            vcms_pkg::FUNC_READ_U:
            begin
                if (wd.pos >= unc_fill)
                    r.status = vcms_pkg::ST_RANGE;
                else
                begin
                    e = unc_list[wd.pos];
                    r.found = 12'(e);
                    r.end_a = end_a_mirror[e];
                    r.end_b = end_b_mirror[e];
                end
            end
            vcms_pkg::FUNC_READ_V:
                show = 1'b1;
            default:
                r.status = vcms_pkg::ST_RANGE;
        endcase
        r.unc_weight = unc_total;
        r.unc_edges  = 13'(unc_fill);
        r.cover_cnt  = 11'(cover_count);
        if (show)
        begin
            r.score   = score_mirror[v];
            r.in_cov  = cov_mirror[v];
            r.changed = mark_mirror[v];
        end
        return r;
    endfunction

    // ---------------- clock, reset, watchdog ----------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------- receiver: random ready bursts, one long hold ----------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // ---------------- result checker ----------------
    initial
    begin
        scorer_result_t want;
        scorer_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.status     = vcms_pkg::status_t'(rsp_ch.status);
                got.unc_weight = rsp_ch.uncovered_weight;
                got.unc_edges  = rsp_ch.uncovered_edges;
                got.cover_cnt  = rsp_ch.cover_size;
                got.found      = rsp_ch.edge_found;
                got.end_a      = rsp_ch.edge_end_a;
                got.end_b      = rsp_ch.edge_end_b;
                got.score      = rsp_ch.vertex_score;
                got.in_cov     = rsp_ch.vertex_in_cover;
                got.changed    = rsp_ch.vertex_changed;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.unc_weight !== want.unc_weight
                        || got.unc_edges !== want.unc_edges
                        || got.cover_cnt !== want.cover_cnt || got.found !== want.found
                        || got.end_a !== want.end_a || got.end_b !== want.end_b
                        || got.score !== want.score || got.in_cov !== want.in_cov
                        || got.changed !== want.changed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
        end
    end

    // ---------------- sender ----------------
    // Offers one word and returns once it is taken; valid stays high if the
    // next word follows without a gap.
    task automatic send_word(scorer_word_t wd);
        scorer_result_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= wd.func;
        req_ch.vertex       <= wd.vtx;
        req_ch.other_vertex <= wd.other;
        req_ch.weight       <= wd.wgt;
        req_ch.position     <= wd.pos;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = score_move(wd);
        if (wd.typed && r.status != wd.status)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("predicted status %s, table says %s", r.status.name(),
                         wd.status.name());
        end
        pending_results.push_back(r);
    endtask

    function automatic scorer_word_t word_of(logic [2:0] f, int v, int u, logic [30:0] w,
                                             int p, bit typed, vcms_pkg::status_t s);
        scorer_word_t wd;
        wd.func = f;
        wd.vtx = 10'(v);
        wd.other = 10'(u);
        wd.wgt = w;
        wd.pos = 12'(p);
        wd.typed = typed;
        wd.status = s;
        return wd;
    endfunction

    // Random word: mostly valid moves on a small vertex set.
    function automatic scorer_word_t random_word();
        int pick;
        int v;
        int u;
        logic [30:0] w;
        pick = $urandom_range(0, 99);
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        if (pick < 30 && loaded_edges < 150)
        begin
            u = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
            w = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1000));
            if (w == 0)
                w = 1;
            return word_of(vcms_pkg::FUNC_LOAD, v, u, w, 0, 0, vcms_pkg::ST_OK);
        end
        if (pick < 65)
        begin
            // Usually flip state; sometimes ask for the state it already has.
            if ($urandom_range(0, 4) == 0)
                return word_of(cov_mirror[v] ? vcms_pkg::FUNC_ADD : vcms_pkg::FUNC_REMOVE,
                               v, 0, 0, 0, 0, vcms_pkg::ST_OK);
            return word_of(cov_mirror[v] ? vcms_pkg::FUNC_REMOVE : vcms_pkg::FUNC_ADD,
                           v, 0, 0, 0, 0, vcms_pkg::ST_OK);
        end
        if (pick < 80)
            return word_of(vcms_pkg::FUNC_READ_U, v, 0, 0,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, unc_fill),
                           0, vcms_pkg::ST_OK);
        if (pick < 95)
            return word_of(vcms_pkg::FUNC_READ_V, v, 0, 0, 0, 0, vcms_pkg::ST_OK);
        return word_of(3'($urandom_range(5, 7)), v, $urandom_range(0, 1023), 31'($urandom),
                       $urandom_range(0, 4095), 0, vcms_pkg::ST_OK);
    endfunction

    // Directed rows; status typed where it is plain from the row itself.
    scorer_word_t directed_rows [$];

    initial
    begin
        int a;
        // Known values on every input from time zero.
        req_ch.valid = 1'b0;
        req_ch.func = vcms_pkg::FUNC_READ_V;
        req_ch.vertex = '0;
        req_ch.other_vertex = '0;
        req_ch.weight = '0;
        req_ch.position = '0;
        quiet = 1'b0;
        hold_request = 1'b0;
        mismatches = 0;
        loaded_edges = 0;
        unc_fill = 0;
        unc_total = '0;
        cover_count = 0;
        for (int i = 0; i < vcms_pkg::MAX_VERTICES; i++)
        begin
            cov_mirror[i] = 1'b0;
            score_mirror[i] = '0;
            mark_mirror[i] = 1'b1;
        end

        directed_rows = '{
            word_of(vcms_pkg::FUNC_READ_V, 0, 0, 0, 0, 1, vcms_pkg::ST_OK),     // fresh
            word_of(vcms_pkg::FUNC_READ_V, 1023, 0, 0, 0, 1, vcms_pkg::ST_OK),  // top vertex
            word_of(vcms_pkg::FUNC_READ_U, 0, 0, 0, 0, 1, vcms_pkg::ST_RANGE),  // empty list
            word_of(vcms_pkg::FUNC_LOAD, 1023, 0, 31'h7FFF_FFFF, 0, 1,
                    vcms_pkg::ST_OK),                                           // weight clamps
            word_of(vcms_pkg::FUNC_LOAD, 1, 1, 5, 0, 1, vcms_pkg::ST_RANGE),    // self loop
            word_of(vcms_pkg::FUNC_LOAD, 1, 2, 1, 0, 1, vcms_pkg::ST_OK),
            word_of(vcms_pkg::FUNC_LOAD, 2, 3, vcms_pkg::MAX_WEIGHT, 0, 1, vcms_pkg::ST_OK),
            word_of(vcms_pkg::FUNC_ADD, 2, 0, 0, 0, 1, vcms_pkg::ST_OK),
            word_of(vcms_pkg::FUNC_ADD, 2, 0, 0, 0, 1, vcms_pkg::ST_SAME),      // already in
            word_of(vcms_pkg::FUNC_LOAD, 2, 4, 5, 0, 1, vcms_pkg::ST_OK),       // first end in
            word_of(vcms_pkg::FUNC_LOAD, 3, 2, 7, 0, 1, vcms_pkg::ST_OK),       // second end in
            word_of(vcms_pkg::FUNC_ADD, 3, 0, 0, 0, 1, vcms_pkg::ST_OK),
            word_of(vcms_pkg::FUNC_LOAD, 2, 3, 9, 0, 1, vcms_pkg::ST_OK),       // both covered
            word_of(vcms_pkg::FUNC_READ_U, 0, 0, 0, 0, 1, vcms_pkg::ST_OK),
            word_of(vcms_pkg::FUNC_READ_U, 0, 0, 0, 4095, 1, vcms_pkg::ST_RANGE),
            word_of(vcms_pkg::FUNC_REMOVE, 5, 0, 0, 0, 1, vcms_pkg::ST_SAME),   // not in cover
            word_of(vcms_pkg::FUNC_REMOVE, 2, 0, 0, 0, 1, vcms_pkg::ST_OK),
            word_of(3'd5, 682, 341, 31'h2AAA_AAAA, 2730, 1, vcms_pkg::ST_RANGE), // unknown
            word_of(3'd7, 341, 682, 31'h5555_5555, 1365, 1, vcms_pkg::ST_RANGE),
            word_of(vcms_pkg::FUNC_READ_V, 2, 0, 0, 0, 1, vcms_pkg::ST_OK),
            word_of(vcms_pkg::FUNC_ADD, 1023, 0, 0, 0, 1, vcms_pkg::ST_OK),
            word_of(vcms_pkg::FUNC_READ_V, 0, 0, 0, 0, 1, vcms_pkg::ST_OK)
        };

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        // Random part; long receiver hold, a drain pause, and a quiet tail.
        for (int i = 0; i < 120; i++)
        begin
            if (i == 40)
                hold_request = 1'b1;
            if (i == 70)
            begin
                req_ch.valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge clk);
            end
            if (i == 90)
                quiet = 1'b1;
            send_word(random_word());
        end

        // A few closing probes around the most recently loaded edge.
        send_word(word_of(vcms_pkg::FUNC_READ_U, 0, 0, 0, 4095, 0, vcms_pkg::ST_OK));
        a = end_a_mirror[loaded_edges - 1];
        send_word(word_of(cov_mirror[a] ? vcms_pkg::FUNC_REMOVE : vcms_pkg::FUNC_ADD,
                          a, 0, 0, 0, 0, vcms_pkg::ST_OK));
        send_word(word_of(vcms_pkg::FUNC_READ_U, 0, 0, 0, $urandom_range(0, unc_fill), 0,
                          vcms_pkg::ST_OK));
        send_word(word_of(vcms_pkg::FUNC_READ_V, a, 0, 0, 0, 0, vcms_pkg::ST_OK));
        req_ch.valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: vertex_cover_move_scorer.f
design/vcms_pkg.sv
design/vcms_if.sv
design/vertex_cover_move_scorer.sv
sim/vertex_cover_move_scorer_test.sv
